>>> sv/vector_distance_kernel_top_macros.svh
// Assertion macros shared by the RTL files.
`ifndef VECTOR_DISTANCE_KERNEL_TOP_MACROS_SVH
`define VECTOR_DISTANCE_KERNEL_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define VDK_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define VDK_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`endif

>>> sv/vdk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vdk_pkg;
   localparam logic [2:0] KSEL_CHI = 3'd0;
   localparam logic [2:0] KSEL_L1 = 3'd1;
   localparam logic [2:0] KSEL_L2 = 3'd2;
   localparam logic [2:0] KSEL_DOT = 3'd3;
   localparam logic [2:0] KSEL_INT = 3'd4;

   // One classified item travelling from the front to the back.
   typedef struct packed {
      logic signed [15:0] value_a;
      logic signed [15:0] value_b;
      logic               last_element;
      logic [2:0]         kernel;
   } item_type;
endpackage
`default_nettype wire

>>> sv/vector_distance_kernel_top.sv
// Channel  Handshake        Payload
// req      valid / stall    value_a, value_b, last_element
// rsp      valid / stall    distance
// csr      valid / ready    kernel_select (3 bits)
// L1, L2 and dot items pass the term and add steps in the back part; chi-square and
// intersection also pass the one-bit-a-cycle divider between them, unless a+b is 0.
// A last item adds an output step to load the result, and an L2 sum passes the root step first.
// Reset clears the running sum, the kernel select and the queue.
// A two-entry queue lets the input keep transferring while the back is busy, until both entries are full.
// A stalled result holds in its register and holds the next last item in the add step.
`timescale 1ns / 1ps
`default_nettype none
module vector_distance_kernel_top (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  signed [15:0]  req_value_a,
   input  wire  signed [15:0]  req_value_b,
   input  wire                 req_last_element,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic signed [47:0]  rsp_distance,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [2:0]          csr_data
);
   import vdk_pkg::*;

   logic [2:0] ksel_ff;
   logic       item_valid, item_take;
   item_type   item;

   // The register takes every write transfer.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) ksel_ff <= KSEL_CHI;
      else if (csr_valid) ksel_ff <= csr_data;
   end

   vdk_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_value_a, .req_value_b,
      .req_last_element, .kernel_select(ksel_ff), .item_valid, .item, .item_take
   );

   vdk_back u_back (
      .clock, .reset, .item_valid, .item, .item_take, .rsp_valid, .rsp_stall,
      .rsp_distance
   );
endmodule
`default_nettype wire

>>> sv/vdk_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-entry input queue towards the back part.
module vdk_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  signed [15:0]   req_value_a,
   input  wire  signed [15:0]   req_value_b,
   input  wire                  req_last_element,
   input  wire  [2:0]           kernel_select,
   output logic                 item_valid,
   output vdk_pkg::item_type    item,
   input  wire                  item_take
);
   import vdk_pkg::*;
   `include "vector_distance_kernel_top_macros.svh"

   item_type   q_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in;
   logic       push, pop;

   // The queue stalls the input only when both entries are full.
   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign pop        = item_take && (count_ff != 2'd0);
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ff];

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      rd_in    = pop ? !rd_ff : rd_ff;
   end

   // Write pointer is the read pointer plus the fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
      end
      if (push) begin
         q_ff[rd_ff ^ count_ff[0]] <= '{req_value_a, req_value_b, req_last_element,
                                        kernel_select};
      end
   end

   `VDK_ASSERT_IMP(a_no_overflow, clock, reset, 1'b1, count_ff <= 2'd2, "queue overflow")
   `VDK_ASSERT_NEXT(a_full_stalls, clock, reset, count_ff == 2'd2 && !item_take,
                    req_stall, "full queue accepted")
endmodule
`default_nettype wire

>>> sv/vdk_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Term computation, accumulation, division and root sequencer.
module vdk_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  item_valid,
   input  vdk_pkg::item_type    item,
   output logic                 item_take,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic signed [47:0]   rsp_distance
);
   import vdk_pkg::*;
   `include "vector_distance_kernel_top_macros.svh"

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TERM = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_ACC  = 3'd3;
   localparam logic [2:0] ST_SQRT = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;
   localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};

   logic [2:0]          st_ff;
   item_type            it_ff;
   logic signed [47:0]  sum_ff;
   logic signed [49:0]  term_ff;
   logic [48:0]         num_ff, rem_ff;
   logic [16:0]         den_ff;
   logic                neg_ff;
   logic [5:0]          cnt_ff;
   logic [63:0]         sx_ff, sres_ff, sbit_ff;
   logic signed [47:0]  dist_ff;
   logic                rv_ff;

   logic signed [16:0]  d, s;
   logic signed [33:0]  dsq, prod;
   logic [16:0]         absd;
   logic signed [15:0]  mn;
   logic signed [50:0]  acc;
   logic signed [47:0]  acc_sat;
   logic [49:0]         rtry;
   logic [63:0]         stry;

   assign item_take    = (st_ff == ST_IDLE) && item_valid;
   assign rsp_valid    = rv_ff;
   assign rsp_distance = dist_ff;

   always_comb begin
      d    = 17'(it_ff.value_a) - 17'(it_ff.value_b);
      s    = 17'(it_ff.value_a) + 17'(it_ff.value_b);
      dsq  = d * d;
      prod = it_ff.value_a * it_ff.value_b;
      absd = d[16] ? 17'(-d) : 17'(d);
      mn   = (it_ff.value_a < it_ff.value_b) ? it_ff.value_a : it_ff.value_b;
      acc  = 51'(sum_ff) + 51'(term_ff);
      if (acc > 51'(SUM_MAX)) acc_sat = SUM_MAX;
      else if (acc < 51'(SUM_MIN)) acc_sat = SUM_MIN;
      else acc_sat = acc[47:0];
      rtry = {rem_ff, num_ff[48]} - {33'd0, den_ff};
      stry = sres_ff + sbit_ff;
   end

   // Sequencer: one item at a time through term, divide, add, root and output steps.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         sum_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         if (rv_ff && !rsp_stall && st_ff != ST_OUT) rv_ff <= 1'b0;
         unique case (st_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  it_ff <= item;
                  st_ff <= ST_TERM;
               end
            end
            ST_TERM: begin
               st_ff <= ST_ACC;
               case (it_ff.kernel) inside
                  KSEL_CHI, KSEL_INT: begin
                     term_ff <= '0;
                     if (s != 0) begin
                        neg_ff <= s[16];
                        den_ff <= s[16] ? 17'(-s) : 17'(s);
                        num_ff <= (it_ff.kernel == KSEL_CHI) ? {7'd0, dsq[33:0], 8'd0}
                                 : 49'(mn[15] ? -(34'(mn)) : 34'(mn)) << 16;
                        if (it_ff.kernel == KSEL_INT) neg_ff <= s[16] ^ mn[15];
                        rem_ff <= '0;
                        cnt_ff <= 6'd0;
                        st_ff  <= ST_DIV;
                     end
                  end
                  KSEL_L1:  term_ff <= 50'(absd) << 8;
                  KSEL_L2:  term_ff <= 50'(dsq);
                  KSEL_DOT: term_ff <= 50'(prod);
                  default:  term_ff <= '0;
               endcase
            end
            ST_DIV: begin
               // Restoring division, one quotient bit a cycle.
               if (!rtry[49]) rem_ff <= rtry[48:0];
               else rem_ff <= {rem_ff[47:0], num_ff[48]};
               num_ff <= {num_ff[47:0], !rtry[49]};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd48) begin
                  term_ff <= neg_ff ? -(50'({num_ff[47:0], !rtry[49]}))
                                    : 50'({num_ff[47:0], !rtry[49]});
                  st_ff   <= ST_ACC;
               end
            end
            ST_ACC: begin
               // A last item waits here while an earlier result is still held.
               if (!it_ff.last_element) begin
                  sum_ff <= acc_sat;
                  st_ff  <= ST_IDLE;
               end else if (!rv_ff || !rsp_stall) begin
                  sum_ff <= '0;
                  if (acc_sat == 0) begin
                     dist_ff <= 48'sd1;
                     st_ff   <= ST_OUT;
                  end else if (it_ff.kernel == KSEL_L2) begin
                     sx_ff   <= acc_sat[47] ? 64'd0 : {acc_sat, 16'd0};
                     sres_ff <= '0;
                     sbit_ff <= 64'd1 << 62;
                     st_ff   <= ST_SQRT;
                  end else begin
                     dist_ff <= acc_sat;
                     st_ff   <= ST_OUT;
                  end
               end
            end
            ST_SQRT: begin
               // Bit-pair square root, one result bit a cycle.
               if (sx_ff >= stry) begin
                  sx_ff   <= sx_ff - stry;
                  sres_ff <= (sres_ff >> 1) + sbit_ff;
               end else begin
                  sres_ff <= sres_ff >> 1;
               end
               sbit_ff <= sbit_ff >> 2;
               if (sbit_ff == 64'd1) begin
                  dist_ff <= (sx_ff >= stry) ? 48'((sres_ff >> 1) + sbit_ff)
                                             : 48'(sres_ff >> 1);
                  st_ff   <= ST_OUT;
               end
            end
            ST_OUT: begin
               rv_ff <= 1'b1;
               st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   `VDK_ASSERT_NEXT(a_rsp_hold, clock, reset, rv_ff && rsp_stall,
                    rv_ff && $stable(dist_ff), "result changed under stall")
   `VDK_ASSERT_IMP(a_take_idle, clock, reset, item_take, st_ff == ST_IDLE,
                   "item taken while busy")
   `VDK_ASSERT_NEXT(a_last_clears, clock, reset,
                    st_ff == ST_ACC && it_ff.last_element && (!rv_ff || !rsp_stall),
                    sum_ff == 0, "sum not cleared after last element")
endmodule
`default_nettype wire
